>>> design/cigar_summary_parser_defines.svh
// assertion macros used by the cigar summary parser top level
`ifndef CIGAR_SUMMARY_PARSER_DEFINES_SVH
`define CIGAR_SUMMARY_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cigar summary parser check failed");

// next-cycle implication, checked out of reset
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cigar summary parser check failed");

`endif

>>> design/csp_pkg.sv
// shared types, character codes and total indexes of the cigar summary parser
package csp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int OUT_W           = 32;
    localparam int TOTAL_NUM       = 9;
    localparam int TDATA_W         = TOTAL_NUM * OUT_W;
    localparam int TUSER_W         = 4;

    // total indexes, in output order
    localparam int T_COL   = 0;
    localparam int T_READ  = 1;
    localparam int T_RSEQ  = 2;
    localparam int T_LCLIP = 3;
    localparam int T_LSOFT = 4;
    localparam int T_GOPEN = 5;
    localparam int T_GBASE = 6;
    localparam int T_INS   = 7;
    localparam int T_DEL   = 8;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
    localparam logic [CHAR_W-1:0] CH_H    = 8'h48;
    localparam logic [CHAR_W-1:0] CH_N    = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADCHAR = 3'd1,
        ST_UNSUP   = 3'd2,
        ST_ZERO    = 3'd3,
        ST_TRAIL   = 3'd4,
        ST_OVF     = 3'd5
    } status_t;

    // decoded character class
    typedef struct packed {
        logic       is_null;
        logic       is_digit;
        logic [3:0] digit;
        logic       op_m;
        logic       op_i;
        logic       op_d;
        logic       op_s;
        logic       op_h;
        logic       is_unsup;
        logic       is_bad;
    } char_class_t;

    // one summary
    typedef struct packed {
        status_t                         status;
        logic                            hard;
        logic [TOTAL_NUM-1:0][OUT_W-1:0] totals;
    } result_t;

endpackage

>>> design/csp_decode.sv
// character classifier: null, digit, supported op, rejected op or illegal character
module csp_decode (
    input  logic [csp_pkg::CHAR_W-1:0] cigar_char,
    output csp_pkg::char_class_t       cls
);
    import csp_pkg::*;

    logic [CHAR_W-1:0] digit_off;

    assign digit_off = cigar_char - CH_ZERO;

    // classify the character
    always_comb
    begin
        cls          = '0;
        cls.is_null  = (cigar_char == CH_NUL);
        cls.is_digit = (cigar_char >= CH_ZERO) && (cigar_char <= CH_NINE);
        cls.digit    = digit_off[3:0];
        cls.op_m     = (cigar_char == CH_M);
        cls.op_i     = (cigar_char == CH_I);
        cls.op_d     = (cigar_char == CH_D);
        cls.op_s     = (cigar_char == CH_S);
        cls.op_h     = (cigar_char == CH_H);
        cls.is_unsup = (cigar_char == CH_N) || (cigar_char == CH_P)
                    || (cigar_char == CH_X) || (cigar_char == CH_EQ);
        cls.is_bad   = !cls.is_null && !cls.is_digit && !cls.is_unsup
                    && !(cls.op_m || cls.op_i || cls.op_d || cls.op_s || cls.op_h);
    end

endmodule

>>> design/csp_accum.sv
// run length and totals state with the per-character update and summary build
module csp_accum #(
    parameter int COUNT_WIDTH = csp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  last,
    input  csp_pkg::char_class_t  cls,
    output csp_pkg::result_t      result
);
    import csp_pkg::*;

    localparam int CNT_W = (COUNT_WIDTH < OUT_W) ? COUNT_WIDTH : OUT_W;

    logic [CNT_W-1:0] run_reg, run_next, run_upd;
    logic             pending_reg, pending_next, pending_upd;
    logic             first_reg, first_next, first_upd;
    logic             hard_reg, hard_next, hard_upd;
    status_t          err_reg, err_next, err_upd, err_out;
    logic [CNT_W-1:0] tot_reg  [TOTAL_NUM];
    logic [CNT_W-1:0] tot_next [TOTAL_NUM];
    logic [CNT_W-1:0] tot_upd  [TOTAL_NUM];
    logic [CNT_W-1:0] add_val  [TOTAL_NUM];
    logic [CNT_W:0]   sum_w    [TOTAL_NUM];
    logic [CNT_W+3:0] run_wide;
    logic             active, is_op, zero_len, do_op, run_ovf, sum_ovf;

    assign active   = !cls.is_null && (err_reg == ST_OK);
    assign is_op    = cls.op_m || cls.op_i || cls.op_d || cls.op_s || cls.op_h;
    assign zero_len = !pending_reg || (run_reg == '0);
    assign do_op    = active && is_op && !zero_len;

    // run times ten plus the new digit, as shifts and adds
    assign run_wide = ({4'b0, run_reg} << 3) + ({4'b0, run_reg} << 1)
                    + {{CNT_W{1'b0}}, cls.digit};
    assign run_ovf  = |run_wide[CNT_W+3:CNT_W];

    // addend of each total for the current op
    always_comb
    begin
        for (int i = 0; i < TOTAL_NUM; i++)
        begin
            add_val[i] = '0;
        end
        if (do_op)
        begin
            if (cls.op_m || cls.op_i || cls.op_d)
                add_val[T_COL] = run_reg;
            if (!cls.op_d)
                add_val[T_READ] = run_reg;
            if (cls.op_s || cls.op_m || cls.op_i)
                add_val[T_RSEQ] = run_reg;
            if (cls.op_d || cls.op_i)
            begin
                add_val[T_GOPEN] = CNT_W'(1);
                add_val[T_GBASE] = run_reg;
            end
            if (cls.op_i)
                add_val[T_INS] = run_reg;
            if (cls.op_d)
                add_val[T_DEL] = run_reg;
        end
    end

    // saturating adds, a carry out means the total passed its maximum
    always_comb
    begin
        sum_ovf = 1'b0;
        for (int i = 0; i < TOTAL_NUM; i++)
        begin
            sum_w[i]   = {1'b0, tot_reg[i]} + {1'b0, add_val[i]};
            tot_upd[i] = sum_w[i][CNT_W] ? {CNT_W{1'b1}} : sum_w[i][CNT_W-1:0];
            sum_ovf    = sum_ovf | sum_w[i][CNT_W];
        end
        // leading clips are written, not added
        tot_upd[T_LCLIP] = tot_reg[T_LCLIP];
        tot_upd[T_LSOFT] = tot_reg[T_LSOFT];
        if (do_op && !first_reg)
        begin
            if (cls.op_s || cls.op_h)
                tot_upd[T_LCLIP] = run_reg;
            if (cls.op_s)
                tot_upd[T_LSOFT] = run_reg;
        end
    end

    // state after this character
    always_comb
    begin
        run_upd     = run_reg;
        pending_upd = pending_reg;
        first_upd   = first_reg;
        hard_upd    = hard_reg;
        err_upd     = err_reg;
        if (active)
        begin
            if (cls.is_digit)
            begin
                run_upd     = run_ovf ? {CNT_W{1'b1}} : run_wide[CNT_W-1:0];
                pending_upd = 1'b1;
                if (run_ovf)
                    err_upd = ST_OVF;
            end
            else if (cls.is_unsup)
                err_upd = ST_UNSUP;
            else if (cls.is_bad)
                err_upd = ST_BADCHAR;
            else if (is_op)
            begin
                if (zero_len)
                    err_upd = ST_ZERO;
                else
                begin
                    run_upd     = '0;
                    pending_upd = 1'b0;
                    first_upd   = 1'b1;
                    hard_upd    = hard_reg | cls.op_h;
                    if (sum_ovf)
                        err_upd = ST_OVF;
                end
            end
        end
        // digits left over at the end of the string
        err_out = err_upd;
        if ((err_upd == ST_OK) && pending_upd)
            err_out = ST_TRAIL;
    end

    // summary fields
    always_comb
    begin
        result.status = err_out;
        result.hard   = hard_upd;
        for (int i = 0; i < TOTAL_NUM; i++)
        begin
            result.totals[i] = OUT_W'(tot_upd[i]);
        end
    end

    // next state: clear after the last character
    always_comb
    begin
        run_next     = run_reg;
        pending_next = pending_reg;
        first_next   = first_reg;
        hard_next    = hard_reg;
        err_next     = err_reg;
        for (int i = 0; i < TOTAL_NUM; i++)
        begin
            tot_next[i] = tot_reg[i];
        end
        if (fire)
        begin
            if (last)
            begin
                run_next     = '0;
                pending_next = 1'b0;
                first_next   = 1'b0;
                hard_next    = 1'b0;
                err_next     = ST_OK;
                for (int i = 0; i < TOTAL_NUM; i++)
                begin
                    tot_next[i] = '0;
                end
            end
            else
            begin
                run_next     = run_upd;
                pending_next = pending_upd;
                first_next   = first_upd;
                hard_next    = hard_upd;
                err_next     = err_upd;
                for (int i = 0; i < TOTAL_NUM; i++)
                begin
                    tot_next[i] = tot_upd[i];
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            pending_reg <= 1'b0;
            first_reg   <= 1'b0;
            hard_reg    <= 1'b0;
            err_reg     <= ST_OK;
            for (int i = 0; i < TOTAL_NUM; i++)
            begin
                tot_reg[i] <= '0;
            end
        end
        else
        begin
            run_reg     <= run_next;
            pending_reg <= pending_next;
            first_reg   <= first_next;
            hard_reg    <= hard_next;
            err_reg     <= err_next;
            for (int i = 0; i < TOTAL_NUM; i++)
            begin
                tot_reg[i] <= tot_next[i];
            end
        end
    end

endmodule

>>> design/cigar_summary_parser.sv
// cigar summary parser top level: input register, update stage, result register
// a summary is loaded into the result register when the update stage consumes its last character
// throughput: one character per cycle unless a last character stalls; each character is one update of the state
// a last character waits in the input register only while a summary sits untaken
// reset (rst_n low, asynchronous) clears the string state and both valid flags
module cigar_summary_parser #(
    parameter int COUNT_WIDTH = csp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [csp_pkg::CHAR_W-1:0]  s_axis_tdata,  // cigar_char
    input  logic                        s_axis_tlast,  // last_char
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // column_total, read_total, read_seq_total, leading_clip, leading_soft_clip,
    // gap_open_count, gap_base_total, insert_total, delete_total (32 bits each)
    output logic [csp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [csp_pkg::TUSER_W-1:0] m_axis_tuser   // hard_clipped, parse_status
);
    import csp_pkg::*;

    `include "cigar_summary_parser_defines.svh"

    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg;
    result_t           result;
    char_class_t       cls;
    logic              out_free, s1_fire, s_take;

    // the update stage consumes a character unless it is a last one facing a full slot
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_fire       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || s1_fire;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    csp_decode u_decode (
        .cigar_char (in_char_reg),
        .cls        (cls)
    );

    csp_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .last   (in_last_reg),
        .cls    (cls),
        .result (result)
    );

    // input register control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
            in_valid_next = 1'b1;
        else if (s1_fire)
            in_valid_next = 1'b0;
    end

    // result register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (s1_fire && in_last_reg)
            result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg.totals;
    assign m_axis_tuser  = {result_reg.status, result_reg.hard};

    // a summary never overwrites one still waiting
    `CSP_ASSERT_NOW(a_no_overwrite, clk, rst_n,
        out_valid_reg && !m_axis_tready && in_valid_reg && in_last_reg, !s1_fire)
    // a consumed last character produces a summary
    `CSP_ASSERT_NEXT(a_summary_loaded, clk, rst_n, s1_fire && in_last_reg, m_axis_tvalid)
    // a clean summary never has a soft clip larger than the whole leading clip
    `CSP_ASSERT_NOW(a_soft_in_clip, clk, rst_n,
        m_axis_tvalid && (result_reg.status == ST_OK),
        result_reg.totals[T_LSOFT] <= result_reg.totals[T_LCLIP])
    // a clean summary without hard clips has equal read and sequence lengths
    `CSP_ASSERT_NOW(a_read_eq_seq, clk, rst_n,
        m_axis_tvalid && (result_reg.status == ST_OK) && !result_reg.hard,
        result_reg.totals[T_READ] == result_reg.totals[T_RSEQ])

endmodule
